// ----- sv/ssdlm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssdlm_pkg
// Shared codes and defaults of the flash line manager.
// ----------------------------------------------------------------------------
package ssdlm_pkg;

    localparam int LINES_DEF       = 256;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int TIME_WIDTH_DEF  = 48;

    // operations
    localparam logic [2:0] OP_WRITE   = 3'd0;
    localparam logic [2:0] OP_INVAL   = 3'd1;
    localparam logic [2:0] OP_ADVANCE = 3'd2;
    localparam logic [2:0] OP_SELECT  = 3'd3;
    localparam logic [2:0] OP_RELEASE = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NO_VIC = 2'd1;
    localparam logic [1:0] ST_NO_FREE = 2'd2;

    // line membership
    localparam logic [2:0] M_FREE     = 3'd0;
    localparam logic [2:0] M_OPEN     = 3'd1;
    localparam logic [2:0] M_FULL     = 3'd2;
    localparam logic [2:0] M_VICTIM   = 3'd3;
    localparam logic [2:0] M_DETACHED = 3'd4;

    // victim policies
    localparam logic [1:0] POL_GREEDY = 2'd0;
    localparam logic [1:0] POL_COST   = 2'd1;
    localparam logic [1:0] POL_OLDEST = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_CHANNELS = 3'd0;
    localparam logic [2:0] CFG_LUNS     = 3'd1;
    localparam logic [2:0] CFG_PLANES   = 3'd2;
    localparam logic [2:0] CFG_PG_BLOCK = 3'd3;
    localparam logic [2:0] CFG_PG_LINE  = 3'd4;
    localparam logic [2:0] CFG_POLICY   = 3'd5;

    localparam int CHUNK_W = 16;

endpackage
`default_nettype wire

// ----- sv/ssd_line_manager_gc_victim_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_line_manager_gc_victim_top
// Flash line manager: page counts, line sets, free ring, write pointer and
// garbage-collection victim selection.
// ----------------------------------------------------------------------------
// Per-line counts, close time and membership live in one table RAM and the
// free ring in a second RAM, both with registered reads. After reset a
// clearing pass over all LINES entries initializes both RAMs; no item is
// taken during it, configuration writes are. One item is handled at a time.
// Page write, page invalidate and release read, update and write back the
// line entry. Advance steps the write pointer, or when the line closes it
// closes the old entry, pops the ring and opens the new entry. Victim
// selection scans every line, then detaches the chosen line if one passes;
// under cost-benefit each line that needs the product compare waits on the
// shared multiply units.
// ----------------------------------------------------------------------------
module ssd_line_manager_gc_victim_top
    import ssdlm_pkg::*;
#(
    parameter int LINES       = LINES_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
    parameter int TIME_WIDTH  = TIME_WIDTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [2:0]  i_operation,
    input  wire logic [7:0]  i_line_id,
    input  wire logic        i_force_req,
    input  wire logic [47:0] i_now,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_status,
    output logic [7:0]       o_victim_line,
    output logic [7:0]       o_wp_line,
    output logic [3:0]       o_wp_channel,
    output logic [3:0]       o_wp_lun,
    output logic [1:0]       o_wp_plane,
    output logic [9:0]       o_wp_page,
    output logic [8:0]       o_free_count,
    output logic [8:0]       o_victim_count,
    output logic [8:0]       o_full_count,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    localparam int LW   = $clog2(LINES);
    localparam int CNTW = $clog2(LINES + 1);
    localparam int CW   = COUNT_WIDTH;
    localparam int TW   = TIME_WIDTH;
    localparam int EW   = 3 + TW + 2 * CW;
    localparam int MW   = (CW > 16) ? CW : 16;
    localparam int PW   = TW + 2 * CW;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_RD, S_UPD, S_ADV, S_ADV_WC, S_ADV_RN, S_ADV_WN,
        S_SC_RD, S_SC_EV, S_SC_MUL, S_SC_END, S_VC_WR, S_DONE
    } t_state;

    t_state r_state;

    // configuration
    logic [4:0]  r_channels, r_luns;
    logic [2:0]  r_planes;
    logic [10:0] r_pg_block;
    logic [15:0] r_ppl;
    logic [1:0]  r_policy;

    // latched item
    logic [2:0]    r_op;
    logic [LW-1:0] r_line;
    logic          r_force;
    logic [TW-1:0] r_now;
    logic [1:0]    r_status;
    logic [LW-1:0] r_victim;

    // line manager state
    logic [LW-1:0]   r_idx, r_head, r_tail, r_nl, r_ptr_line;
    logic [CNTW-1:0] r_free, r_vict, r_full;
    logic [3:0]      r_ptr_ch, r_ptr_lun;
    logic [1:0]      r_ptr_pl;
    logic [9:0]      r_ptr_pg;

    // scan state
    logic          r_found;
    logic [LW-1:0] r_b_idx;
    logic [CW-1:0] r_b_val, r_b_inv;
    logic [TW-1:0] r_b_time, r_b_age;

    // result word
    logic [1:0] r_o_status;
    logic [7:0] r_o_victim, r_o_line;
    logic [3:0] r_o_ch, r_o_lun;
    logic [1:0] r_o_pl;
    logic [9:0] r_o_pg;
    logic [8:0] r_o_free, r_o_vict, r_o_full;
    logic       r_o_valid;

    // RAM ports
    logic          tbl_we, tbl_re, ring_we, ring_re;
    logic [LW-1:0] tbl_waddr, tbl_raddr, ring_waddr, ring_raddr;
    logic [EW-1:0] tbl_wdata, tbl_rdata;
    logic [LW-1:0] ring_wdata, ring_rdata;

    logic [CW-1:0] e_val, e_inv;
    logic [TW-1:0] e_time, w_age;
    logic [2:0]    e_mem;

    logic          in_acc, out_free, in_range;
    logic          mul_start, mul_done1, mul_done2;
    logic [PW-1:0] prod1, prod2;

    // pointer step
    logic [4:0]  w_nch, w_nlun, w_ch1, w_lun1;
    logic [2:0]  w_npl, w_pl1;
    logic [10:0] w_npg, w_pg1;
    logic [3:0]  n_ptr_ch, n_ptr_lun;
    logic [1:0]  n_ptr_pl;
    logic [9:0]  n_ptr_pg;
    logic        w_wrap;

    // scan decision
    logic w_need_mul, w_better, w_thr_fail;

    assign e_val  = tbl_rdata[CW-1:0];
    assign e_inv  = tbl_rdata[2*CW-1:CW];
    assign e_time = tbl_rdata[2*CW+TW-1:2*CW];
    assign e_mem  = tbl_rdata[EW-1:2*CW+TW];
    assign w_age  = r_now - e_time;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_o_valid || i_out_ready;
    assign in_range    = 32'(i_line_id) < LINES;
    assign mul_start   = (r_state == S_SC_EV) && w_need_mul;

    ssdlm_ram #(.WIDTH(EW), .DEPTH(LINES)) u_tbl (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_re    (tbl_re),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

    ssdlm_ram #(.WIDTH(LW), .DEPTH(LINES)) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (ring_waddr),
        .i_wdata (ring_wdata),
        .i_re    (ring_re),
        .i_raddr (ring_raddr),
        .o_rdata (ring_rdata)
    );

    // candidate side: age * inv * leader valid count
    ssdlm_cbmul #(.TIME_WIDTH(TW), .COUNT_WIDTH(CW)) u_mul_cand (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_age   (w_age),
        .i_a     (e_inv),
        .i_b     (r_b_val),
        .o_done  (mul_done1),
        .o_prod  (prod1)
    );

    // leader side: leader age * leader invalid count * val
    ssdlm_cbmul #(.TIME_WIDTH(TW), .COUNT_WIDTH(CW)) u_mul_best (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_age   (r_b_age),
        .i_a     (r_b_inv),
        .i_b     (e_val),
        .o_done  (mul_done2),
        .o_prod  (prod2)
    );

    // clamp geometry and step channel, lun, plane, page
    always_comb begin
        w_nch  = (r_channels == 5'd0) ? 5'd1 : ((r_channels > 5'd16) ? 5'd16 : r_channels);
        w_nlun = (r_luns == 5'd0) ? 5'd1 : ((r_luns > 5'd16) ? 5'd16 : r_luns);
        w_npl  = (r_planes == 3'd0) ? 3'd1 : ((r_planes > 3'd4) ? 3'd4 : r_planes);
        w_npg  = (r_pg_block == 11'd0) ? 11'd1 :
                 ((r_pg_block > 11'd1024) ? 11'd1024 : r_pg_block);
        w_ch1  = {1'b0, r_ptr_ch} + 5'd1;
        w_lun1 = {1'b0, r_ptr_lun} + 5'd1;
        w_pl1  = {1'b0, r_ptr_pl} + 3'd1;
        w_pg1  = {1'b0, r_ptr_pg} + 11'd1;
        n_ptr_ch  = r_ptr_ch;
        n_ptr_lun = r_ptr_lun;
        n_ptr_pl  = r_ptr_pl;
        n_ptr_pg  = r_ptr_pg;
        w_wrap    = 1'b0;
        if (w_ch1 < w_nch) begin
            n_ptr_ch = w_ch1[3:0];
        end else begin
            n_ptr_ch = '0;
            if (w_lun1 < w_nlun) begin
                n_ptr_lun = w_lun1[3:0];
            end else begin
                n_ptr_lun = '0;
                if (w_pl1 < w_npl) begin
                    n_ptr_pl = w_pl1[1:0];
                end else begin
                    n_ptr_pl = '0;
                    if (w_pg1 < w_npg) begin
                        n_ptr_pg = w_pg1[9:0];
                    end else begin
                        n_ptr_pg = '0;
                        w_wrap   = 1'b1;
                    end
                end
            end
        end
    end

    // victim scan compare, first stage
    always_comb begin
        w_need_mul = 1'b0;
        w_better   = 1'b0;
        case (r_policy)
            POL_COST: begin
                if (e_val == '0) begin
                    w_better = !(r_found && r_b_val == '0);
                end else if (r_found && r_b_val == '0) begin
                    w_better = 1'b0;
                end else if (!r_found) begin
                    w_better = 1'b1;
                end else begin
                    w_need_mul = 1'b1;
                end
            end
            POL_OLDEST: w_better = !r_found || (e_time < r_b_time);
            default:    w_better = !r_found || (e_val < r_b_val);
        endcase
        if (e_mem != M_VICTIM) begin
            w_better   = 1'b0;
            w_need_mul = 1'b0;
        end
        w_thr_fail = !r_force && (MW'(r_b_inv) < MW'(r_ppl >> 3));
    end

    // RAM control
    always_comb begin
        tbl_we     = 1'b0;
        tbl_re     = 1'b0;
        tbl_waddr  = r_line;
        tbl_raddr  = r_line;
        tbl_wdata  = tbl_rdata;
        ring_we    = 1'b0;
        ring_re    = 1'b0;
        ring_waddr = r_tail;
        ring_raddr = r_head;
        ring_wdata = r_line;
        unique case (r_state)
            S_CLR: begin
                tbl_we     = 1'b1;
                tbl_waddr  = r_idx;
                tbl_wdata  = {((r_idx == '0) ? M_OPEN : M_FREE), {(TW + 2 * CW){1'b0}}};
                ring_we    = 1'b1;
                ring_waddr = r_idx;
                ring_wdata = r_idx;
            end
            S_RD: tbl_re = 1'b1;
            S_UPD: begin
                case (r_op)
                    OP_WRITE: begin
                        tbl_we = 1'b1;
                        if (MW'(e_val) < MW'(r_ppl) && e_val != '1) begin
                            tbl_wdata = {e_mem, e_time, e_inv, e_val + 1'b1};
                        end
                    end
                    OP_INVAL: begin
                        tbl_we    = e_val != '0;
                        tbl_wdata = {((e_mem == M_FULL) ? M_VICTIM : e_mem), e_time,
                                     ((e_inv == '1) ? e_inv : e_inv + 1'b1), e_val - 1'b1};
                    end
                    default: begin
                        // release
                        tbl_we    = !(e_mem == M_FREE || e_mem == M_OPEN);
                        tbl_wdata = {M_FREE, {(TW + 2 * CW){1'b0}}};
                        ring_we   = tbl_we;
                    end
                endcase
            end
            S_ADV: begin
                tbl_re    = 1'b1;
                tbl_raddr = r_ptr_line;
                ring_re   = 1'b1;
            end
            S_ADV_WC: begin
                tbl_we    = 1'b1;
                tbl_waddr = r_ptr_line;
                tbl_wdata = {((MW'(e_val) == MW'(r_ppl)) ? M_FULL : M_VICTIM), r_now, e_inv, e_val};
            end
            S_ADV_RN: begin
                tbl_re    = 1'b1;
                tbl_raddr = r_nl;
            end
            S_ADV_WN: begin
                tbl_we    = 1'b1;
                tbl_waddr = r_nl;
                tbl_wdata = {M_OPEN, e_time, e_inv, e_val};
            end
            S_SC_RD: begin
                tbl_re    = 1'b1;
                tbl_raddr = r_idx;
            end
            S_SC_END: begin
                tbl_re    = 1'b1;
                tbl_raddr = r_b_idx;
            end
            S_VC_WR: begin
                tbl_we    = 1'b1;
                tbl_waddr = r_b_idx;
                tbl_wdata = {M_DETACHED, e_time, e_inv, e_val};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_idx      <= '0;
            r_channels <= 5'd8;
            r_luns     <= 5'd8;
            r_planes   <= 3'd1;
            r_pg_block <= 11'd256;
            r_ppl      <= 16'd16384;
            r_policy   <= POL_GREEDY;
            r_head     <= LW'(1);
            r_tail     <= '0;
            r_free     <= CNTW'(LINES - 1);
            r_vict     <= '0;
            r_full     <= '0;
            r_ptr_line <= '0;
            r_ptr_ch   <= '0;
            r_ptr_lun  <= '0;
            r_ptr_pl   <= '0;
            r_ptr_pg   <= '0;
            r_found    <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_CHANNELS: r_channels <= i_cfg_data[4:0];
                    CFG_LUNS:     r_luns     <= i_cfg_data[4:0];
                    CFG_PLANES:   r_planes   <= i_cfg_data[2:0];
                    CFG_PG_BLOCK: r_pg_block <= i_cfg_data[10:0];
                    CFG_PG_LINE:  r_ppl      <= i_cfg_data;
                    CFG_POLICY:   r_policy   <= i_cfg_data[1:0];
                    default: ;
                endcase
            end

            // drop the word once taken, unless a new one loads this cycle
            if (r_o_valid && i_out_ready && r_state != S_DONE) begin
                r_o_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLR: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == LW'(LINES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_op     <= i_operation;
                        r_line   <= LW'(i_line_id);
                        r_force  <= i_force_req;
                        r_now    <= TW'(i_now);
                        r_status <= (i_operation == OP_ADVANCE && w_wrap && r_free == '0) ?
                                    ST_NO_FREE : ST_OK;
                        r_victim <= '0;
                        r_idx    <= '0;
                        r_found  <= 1'b0;
                        case (i_operation)
                            OP_WRITE, OP_INVAL, OP_RELEASE:
                                r_state <= in_range ? S_RD : S_DONE;
                            OP_ADVANCE: begin
                                if (!w_wrap) begin
                                    r_ptr_ch  <= n_ptr_ch;
                                    r_ptr_lun <= n_ptr_lun;
                                    r_ptr_pl  <= n_ptr_pl;
                                    r_ptr_pg  <= n_ptr_pg;
                                    r_state   <= S_DONE;
                                end else if (r_free == '0) begin
                                    r_state <= S_DONE;
                                end else begin
                                    r_state <= S_ADV;
                                end
                            end
                            OP_SELECT: r_state <= S_SC_RD;
                            default:   r_state <= S_DONE;
                        endcase
                    end
                end
                S_RD: r_state <= S_UPD;
                S_UPD: begin
                    if (r_op == OP_INVAL && e_val != '0 && e_mem == M_FULL) begin
                        r_full <= r_full - 1'b1;
                        r_vict <= r_vict + 1'b1;
                    end
                    if (r_op == OP_RELEASE && !(e_mem == M_FREE || e_mem == M_OPEN)) begin
                        if (e_mem == M_FULL) begin
                            r_full <= r_full - 1'b1;
                        end else if (e_mem == M_VICTIM) begin
                            r_vict <= r_vict - 1'b1;
                        end
                        r_tail <= (r_tail == LW'(LINES - 1)) ? '0 : r_tail + 1'b1;
                        r_free <= r_free + 1'b1;
                    end
                    r_state <= S_DONE;
                end
                S_ADV: r_state <= S_ADV_WC;
                S_ADV_WC: begin
                    if (MW'(e_val) == MW'(r_ppl)) begin
                        r_full <= r_full + 1'b1;
                    end else begin
                        r_vict <= r_vict + 1'b1;
                    end
                    r_nl    <= ring_rdata;
                    r_head  <= (r_head == LW'(LINES - 1)) ? '0 : r_head + 1'b1;
                    r_free  <= r_free - 1'b1;
                    r_state <= S_ADV_RN;
                end
                S_ADV_RN: r_state <= S_ADV_WN;
                S_ADV_WN: begin
                    r_ptr_line <= r_nl;
                    r_ptr_ch   <= '0;
                    r_ptr_lun  <= '0;
                    r_ptr_pl   <= '0;
                    r_ptr_pg   <= '0;
                    r_state    <= S_DONE;
                end
                S_SC_RD: r_state <= S_SC_EV;
                S_SC_EV, S_SC_MUL: begin
                    if (r_state == S_SC_EV && w_need_mul) begin
                        r_state <= S_SC_MUL;
                    end else if (r_state == S_SC_EV || (mul_done1 && mul_done2)) begin
                        if ((r_state == S_SC_EV) ? w_better : (prod1 > prod2)) begin
                            r_found  <= 1'b1;
                            r_b_idx  <= r_idx;
                            r_b_val  <= e_val;
                            r_b_inv  <= e_inv;
                            r_b_time <= e_time;
                            r_b_age  <= w_age;
                        end
                        // advance to the next line or finish
                        if (r_idx == LW'(LINES - 1)) begin
                            r_state <= S_SC_END;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_SC_RD;
                        end
                    end
                end
                S_SC_END: begin
                    if (!r_found || w_thr_fail) begin
                        r_status <= ST_NO_VIC;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_VC_WR;
                    end
                end
                S_VC_WR: begin
                    r_vict   <= r_vict - 1'b1;
                    r_victim <= r_b_idx;
                    r_state  <= S_DONE;
                end
                S_DONE: begin
                    // hold until the output register frees up
                    if (out_free) begin
                        r_o_valid  <= 1'b1;
                        r_o_status <= r_status;
                        r_o_victim <= 8'(r_victim);
                        r_o_line   <= 8'(r_ptr_line);
                        r_o_ch     <= r_ptr_ch;
                        r_o_lun    <= r_ptr_lun;
                        r_o_pl     <= r_ptr_pl;
                        r_o_pg     <= r_ptr_pg;
                        r_o_free   <= 9'(r_free);
                        r_o_vict   <= 9'(r_vict);
                        r_o_full   <= 9'(r_full);
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_status       = r_o_status;
    assign o_victim_line  = r_o_victim;
    assign o_wp_line      = r_o_line;
    assign o_wp_channel   = r_o_ch;
    assign o_wp_lun       = r_o_lun;
    assign o_wp_plane     = r_o_pl;
    assign o_wp_page      = r_o_pg;
    assign o_free_count   = r_o_free;
    assign o_victim_count = r_o_vict;
    assign o_full_count   = r_o_full;

endmodule
`default_nettype wire

// ----- sv/ssdlm_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssdlm_ram
// Generic one-write, one-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module ssdlm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ----- sv/ssdlm_cbmul.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssdlm_cbmul
// Multi-cycle product age * a * b for the cost-benefit compare: a * b is
// registered first, then one 16-bit slice of age per cycle into an accumulator.
// ----------------------------------------------------------------------------
module ssdlm_cbmul
    import ssdlm_pkg::*;
#(
    parameter int TIME_WIDTH  = TIME_WIDTH_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_start,
    input  wire logic [TIME_WIDTH-1:0]                i_age,
    input  wire logic [COUNT_WIDTH-1:0]               i_a,
    input  wire logic [COUNT_WIDTH-1:0]               i_b,
    output logic                                      o_done,
    output logic      [TIME_WIDTH+2*COUNT_WIDTH-1:0]  o_prod
);

    localparam int NCH = (TIME_WIDTH + CHUNK_W - 1) / CHUNK_W;
    localparam int AGW = NCH * CHUNK_W;
    localparam int PPW = 2 * COUNT_WIDTH;
    localparam int PW  = TIME_WIDTH + PPW;
    localparam int KW  = (NCH > 1) ? $clog2(NCH) : 1;

    logic                   r_busy;
    logic [KW-1:0]          r_k;
    logic [PPW-1:0]         r_p;
    logic [AGW-1:0]         r_age;
    logic [PW-1:0]          r_acc;
    logic [CHUNK_W-1:0]     w_chunk;
    logic [PPW+CHUNK_W-1:0] w_part;

    assign w_chunk = CHUNK_W'(r_age >> (CHUNK_W * r_k));
    assign w_part  = (PPW+CHUNK_W)'(r_p) * (PPW+CHUNK_W)'(w_chunk);
    assign o_prod  = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_k    <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_k    <= '0;
                r_acc  <= '0;
                r_p    <= PPW'(i_a) * PPW'(i_b);
                r_age  <= AGW'(i_age);
            end else if (r_busy) begin
                r_acc <= r_acc + (PW'(w_part) << (CHUNK_W * r_k));
                if (r_k == KW'(NCH - 1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end else begin
                    r_k <= r_k + 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire
